@@ design/aftpc_pkg.sv @@
// Package for the tuner front-panel controller.
// Holds command and status codes, band limits and the request and result types.
// No dependencies.
`timescale 1ns / 1ps

package aftpc_pkg;

    // Command codes carried by each request.
    typedef enum logic [2:0] {
        CMD_POWER_TOGGLE  = 3'd0,
        CMD_SET_VOLUME    = 3'd1,
        CMD_BAND_TOGGLE   = 3'd2,
        CMD_STORE_PRESET  = 3'd3,
        CMD_RECALL_PRESET = 3'd4,
        CMD_SCAN_UP       = 3'd5,
        CMD_SCAN_DOWN     = 3'd6,
        CMD_NONE          = 3'd7
    } cmd_t;

    // Status codes returned with every result.
    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_VOL_CLAMP  = 2'd1,
        STATUS_BAD_PRESET = 2'd2,
        STATUS_SPARE      = 2'd3
    } status_t;

    // Band limits: AM in kHz, FM in tenths of MHz.
    localparam logic [10:0] AM_LOW  = 11'd530;
    localparam logic [10:0] AM_HIGH = 11'd1700;
    localparam logic [10:0] AM_STEP = 11'd10;
    localparam logic [10:0] FM_LOW  = 11'd879;
    localparam logic [10:0] FM_HIGH = 11'd1079;
    localparam logic [10:0] FM_STEP = 11'd2;

    // Volume ceiling.
    localparam logic [6:0] VOL_MAX = 7'd100;

    typedef struct packed {
        logic [2:0]        req_type;
        logic signed [7:0] volume_request;
        logic [3:0]        preset_index;
    } request_t;

    typedef struct packed {
        logic        powered;
        logic        band_fm;
        logic [10:0] station;
        logic [6:0]  volume_level;
        logic [1:0]  status;
    } result_t;

endpackage

@@ design/aftpc_input_stage.sv @@
// Input register of the tuner front-panel controller.
// Captures one request per transfer; uses aftpc_pkg.
`timescale 1ns / 1ps

module aftpc_input_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  aftpc_pkg::request_t req_in,
    input  logic               out_free,
    output logic               take,
    output aftpc_pkg::request_t req_out
);
    import aftpc_pkg::*;

    logic     in_v_reg;
    logic     in_v_next;
    request_t req_reg;

    // The held request moves on when the result register can take it.
    assign take     = in_v_reg && out_free;
    assign in_ready = !in_v_reg || take;
    assign req_out  = req_reg;

    always_comb
    begin
        in_v_next = in_v_reg;
        if (in_ready)
        begin
            in_v_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg <= in_v_next;
        end
    end

    // Payload register, loaded on every accepted transfer.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= req_in;
        end
    end

endmodule

@@ design/aftpc_core.sv @@
// Tuner state and command execution for the front-panel controller.
// State registers update when a request is taken; uses aftpc_pkg.
`timescale 1ns / 1ps

module aftpc_core #(
    parameter int PRESET_COUNT = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  aftpc_pkg::request_t req,
    output aftpc_pkg::result_t  result
);
    import aftpc_pkg::*;

    localparam int          IDX_W        = (PRESET_COUNT > 1) ? $clog2(PRESET_COUNT) : 1;
    localparam logic [4:0]  PRESET_LIMIT = 5'(PRESET_COUNT);

    logic        power_reg,   power_next;
    logic        fm_reg,      fm_next;
    logic [10:0] station_reg, station_next;
    logic [6:0]  live_reg,    live_next;
    logic [6:0]  saved_reg,   saved_next;
    logic [10:0] last_am_reg, last_am_next;
    logic [10:0] last_fm_reg, last_fm_next;
    logic [10:0] am_presets_reg [PRESET_COUNT];
    logic [10:0] fm_presets_reg [PRESET_COUNT];

    logic             idx_ok;
    logic [IDX_W-1:0] pidx;
    logic [10:0]      preset_value;
    logic             store_am;
    logic             store_fm;
    logic [6:0]       vol_clamped;
    logic             vol_over;
    status_t          status_next;

    // Preset index check and the selected preset of the current band.
    assign idx_ok       = {1'b0, req.preset_index} < PRESET_LIMIT;
    assign pidx         = idx_ok ? req.preset_index[IDX_W-1:0] : '0;
    assign preset_value = fm_reg ? fm_presets_reg[pidx] : am_presets_reg[pidx];

    // Volume request clamped to the legal range.
    always_comb
    begin
        vol_over = 1'b0;
        if (req.volume_request < 8'sd0)
        begin
            vol_clamped = 7'd0;
        end
        else if (req.volume_request > $signed({1'b0, VOL_MAX}))
        begin
            vol_clamped = VOL_MAX;
            vol_over    = 1'b1;
        end
        else
        begin
            vol_clamped = req.volume_request[6:0];
        end
    end

    // Next state for the command in the input register.
    always_comb
    begin
        power_next   = power_reg;
        fm_next      = fm_reg;
        station_next = station_reg;
        live_next    = live_reg;
        saved_next   = saved_reg;
        last_am_next = last_am_reg;
        last_fm_next = last_fm_reg;
        store_am     = 1'b0;
        store_fm     = 1'b0;
        status_next  = STATUS_OK;
        case (cmd_t'(req.req_type))
            CMD_POWER_TOGGLE:
            begin
                power_next = !power_reg;
                live_next  = power_reg ? 7'd0 : saved_reg;
            end
            CMD_SET_VOLUME:
            begin
                saved_next = vol_clamped;
                live_next  = power_reg ? vol_clamped : 7'd0;
                if (vol_over)
                begin
                    status_next = STATUS_VOL_CLAMP;
                end
            end
            CMD_BAND_TOGGLE:
            begin
                fm_next      = !fm_reg;
                station_next = fm_reg ? last_am_reg : last_fm_reg;
            end
            CMD_STORE_PRESET:
            begin
                if (idx_ok)
                begin
                    store_am = !fm_reg;
                    store_fm = fm_reg;
                end
                else
                begin
                    status_next = STATUS_BAD_PRESET;
                end
            end
            CMD_RECALL_PRESET:
            begin
                if (idx_ok)
                begin
                    station_next = preset_value;
                end
                else
                begin
                    status_next = STATUS_BAD_PRESET;
                end
            end
            CMD_SCAN_UP:
            begin
                if (fm_reg)
                begin
                    station_next = (station_reg >= FM_HIGH) ? FM_LOW : station_reg + FM_STEP;
                    last_fm_next = station_next;
                end
                else
                begin
                    station_next = (station_reg >= AM_HIGH) ? AM_LOW : station_reg + AM_STEP;
                    last_am_next = station_next;
                end
            end
            CMD_SCAN_DOWN:
            begin
                if (fm_reg)
                begin
                    station_next = (station_reg <= FM_LOW) ? FM_HIGH : station_reg - FM_STEP;
                    last_fm_next = station_next;
                end
                else
                begin
                    station_next = (station_reg <= AM_LOW) ? AM_HIGH : station_reg - AM_STEP;
                    last_am_next = station_next;
                end
            end
            default:
            begin
                status_next = STATUS_OK;
            end
        endcase
    end

    // Result shows the state after the command.
    assign result.powered      = power_next;
    assign result.band_fm      = fm_next;
    assign result.station      = station_next;
    assign result.volume_level = power_next ? live_next : 7'd0;
    assign result.status       = status_next;

    // Scalar tuner state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_reg   <= 1'b0;
            fm_reg      <= 1'b0;
            station_reg <= AM_LOW;
            live_reg    <= 7'd0;
            saved_reg   <= 7'd0;
            last_am_reg <= AM_LOW;
            last_fm_reg <= FM_LOW;
        end
        else if (take)
        begin
            power_reg   <= power_next;
            fm_reg      <= fm_next;
            station_reg <= station_next;
            live_reg    <= live_next;
            saved_reg   <= saved_next;
            last_am_reg <= last_am_next;
            last_fm_reg <= last_fm_next;
        end
    end

    // Preset banks, one entry written per store command.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PRESET_COUNT; i++)
            begin
                am_presets_reg[i] <= AM_LOW;
                fm_presets_reg[i] <= FM_LOW;
            end
        end
        else if (take)
        begin
            if (store_am)
            begin
                am_presets_reg[pidx] <= station_reg;
            end
            if (store_fm)
            begin
                fm_presets_reg[pidx] <= station_reg;
            end
        end
    end

endmodule

@@ design/aftpc_output_stage.sv @@
// Result register of the tuner front-panel controller.
// Holds one result until its transfer; uses aftpc_pkg.
`timescale 1ns / 1ps

module aftpc_output_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  aftpc_pkg::result_t result_in,
    output logic               out_free,
    output logic               out_valid,
    input  logic               out_ready,
    output aftpc_pkg::result_t result_out
);
    import aftpc_pkg::*;

    logic    out_v_reg;
    logic    out_v_next;
    result_t result_reg;

    assign out_free   = !out_v_reg || out_ready;
    assign out_valid  = out_v_reg;
    assign result_out = result_reg;

    // Valid follows a new result, or drops once the held one is taken.
    always_comb
    begin
        out_v_next = out_v_reg;
        if (take)
        begin
            out_v_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_in;
        end
    end

endmodule

@@ design/am_fm_tuner_panel_control.sv @@
// Top level of the AM/FM tuner front-panel controller.
// Instantiates aftpc_input_stage, aftpc_core and aftpc_output_stage; uses aftpc_pkg.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+---------------------------------------------------
//   input   | in_valid / in_ready  | req_type, volume_request, preset_index
//   output  | out_valid / out_ready| powered, band_fm, station, volume_level, status
//
// Each command passes through the input register and the core into the result register;
// one command is accepted every cycle while out_ready is high.
// Reset (rst_n low): power off, AM band, volumes 0, station and presets at low limits.
// When out_ready is low the result register holds and one more command waits in
// the input register; in_ready drops only when both are full.
`timescale 1ns / 1ps

module am_fm_tuner_panel_control #(
    parameter int PRESET_COUNT = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        req_type,
    input  logic signed [7:0] volume_request,
    input  logic [3:0]        preset_index,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              powered,
    output logic              band_fm,
    output logic [10:0]       station,
    output logic [6:0]        volume_level,
    output logic [1:0]        status
);
    import aftpc_pkg::*;

    request_t req_in;
    request_t req_held;
    result_t  result_next;
    result_t  result_held;
    logic     take;
    logic     out_free;

    assign req_in.req_type       = req_type;
    assign req_in.volume_request = volume_request;
    assign req_in.preset_index   = preset_index;

    aftpc_input_stage u_input (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_in   (req_in),
        .out_free (out_free),
        .take     (take),
        .req_out  (req_held)
    );

    aftpc_core #(
        .PRESET_COUNT (PRESET_COUNT)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .req    (req_held),
        .result (result_next)
    );

    aftpc_output_stage u_output (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .result_in  (result_next),
        .out_free   (out_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_out (result_held)
    );

    // Result fields onto their ports.
    assign powered      = result_held.powered;
    assign band_fm      = result_held.band_fm;
    assign station      = result_held.station;
    assign volume_level = result_held.volume_level;
    assign status       = result_held.status;

endmodule

@@ design/aftpc_checker.sv @@
// Port-level checks for the tuner front-panel controller, bound to its top level.
// Depends on am_fm_tuner_panel_control and aftpc_pkg.
`timescale 1ns / 1ps

module aftpc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        powered,
    input logic        band_fm,
    input logic [10:0] station,
    input logic [6:0]  volume_level,
    input logic [1:0]  status
);
    import aftpc_pkg::*;

    // A stalled result keeps its valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

    // A radio that is off shows no volume.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !powered |-> volume_level == 7'd0)
    else $error("volume shown while powered off");

    // The station lies within the band that is shown.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (band_fm ? (station >= FM_LOW && station <= FM_HIGH)
                               : (station >= AM_LOW && station <= AM_HIGH)))
    else $error("station outside its band");

    // A clamp status goes with full volume or a radio that is off.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_VOL_CLAMP |-> volume_level == VOL_MAX || !powered)
    else $error("clamp status without full volume");

    // The spare status code never appears.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != STATUS_SPARE)
    else $error("unused status code");

endmodule

bind am_fm_tuner_panel_control aftpc_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .powered      (powered),
    .band_fm      (band_fm),
    .station      (station),
    .volume_level (volume_level),
    .status       (status)
);
